[sv/ckms_pkg.sv]
// Shared types and constants for the capacitive key matrix scanner.
// Holds the fixed key code table and the configuration register indexes.
// No dependencies.
package ckms_pkg;

    // configuration register indexes
    typedef enum logic [0:0] {
        CFG_CALIBRATE_MODE   = 1'b0,
        CFG_THRESHOLD_MARGIN = 1'b1
    } cfg_idx_t;

    localparam logic [7:0] MARGIN_RESET = 8'd2;

    localparam int TABLE_ROWS = 5;
    localparam int TABLE_COLS = 9;

    // field widths of the stream payloads
    localparam int ROW_W   = 3;
    localparam int COL_W   = 4;
    localparam int CHG_W   = 16;
    localparam int CODE_W  = 8;
    localparam int FOUND_W = 3;
    localparam int MAX_SLOTS = 6;

    localparam logic [CODE_W-1:0] KEY_TABLE [TABLE_ROWS][TABLE_COLS] = '{
        '{8'h28, 8'h29, 8'h2C, 8'd33, 8'd34, 8'h1E, 8'h50, 8'h4F, 8'd33},
        '{8'd20, 8'd26, 8'd8,  8'd21, 8'd23, 8'd20, 8'd26, 8'd8,  8'd21},
        '{8'h04, 8'h16, 8'h07, 8'h09, 8'h0A, 8'h04, 8'h16, 8'h07, 8'h09},
        '{8'h1D, 8'h1B, 8'h06, 8'h19, 8'h05, 8'h1D, 8'h1B, 8'h06, 8'h19},
        '{8'h00, 8'h00, 8'h00, 8'h2C, 8'h00, 8'h00, 8'h00, 8'h00, 8'h2C}
    };

    // code of a matrix position, zero outside the table
    function automatic logic [CODE_W-1:0] key_code(input logic [ROW_W-1:0] row,
                                                    input logic [COL_W-1:0] col);
        logic [CODE_W-1:0] code;
        code = '0;
        if ((int'(row) < TABLE_ROWS) && (int'(col) < TABLE_COLS)) begin
            code = KEY_TABLE[row][col];
        end
        return code;
    endfunction

endpackage

[sv/ckms_thr_store.sv]
// Per-key idle threshold memory with per-entry valid bits and write bypass.
// Uses ckms_pkg nothing; standalone storage for the scanner.
// Read data is registered; a write at the read edge is forwarded.
module ckms_thr_store #(
    parameter int KEYS       = 45,
    parameter int IW         = 6,
    parameter int COUNT_BITS = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  rd_en,
    input  logic [IW-1:0]         rd_addr,
    input  logic                  wr_en,
    input  logic [IW-1:0]         wr_addr,
    input  logic [COUNT_BITS-1:0] wr_data,
    output logic [COUNT_BITS-1:0] rd_thr
);

    logic [COUNT_BITS-1:0] mem [KEYS];
    logic [KEYS-1:0]       vld_reg;
    logic [COUNT_BITS-1:0] mem_q_reg;
    logic                  vld_q_reg;
    logic                  hit_reg;
    logic [COUNT_BITS-1:0] byp_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            mem_q_reg <= mem[rd_addr];
            byp_reg   <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg   <= '0;
            vld_q_reg <= 1'b0;
            hit_reg   <= 1'b0;
        end else begin
            if (wr_en) begin
                vld_reg[wr_addr] <= 1'b1;
            end
            if (rd_en) begin
                vld_q_reg <= vld_reg[rd_addr];
                hit_reg   <= wr_en && (wr_addr == rd_addr);
            end
        end
    end

    // an entry never written reads as zero
    assign rd_thr = hit_reg   ? byp_reg :
                    vld_q_reg ? mem_q_reg : '0;

endmodule

[sv/ckms_scan_core.sv]
// Decision logic and report state of the scanner: running maximum,
// threshold learning, report slots and indicator. Depends on ckms_pkg.
module ckms_scan_core #(
    parameter int IW           = 6,
    parameter int COUNT_BITS   = 16,
    parameter int REPORT_SLOTS = 6
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               fire,
    input  logic                               calibrate,
    input  logic [7:0]                         margin,
    input  logic [ckms_pkg::ROW_W-1:0]         row,
    input  logic [ckms_pkg::COL_W-1:0]         col,
    input  logic [ckms_pkg::CHG_W-1:0]         charge,
    input  logic                               last_sample,
    input  logic                               last_key,
    input  logic                               key_ok,
    input  logic [IW-1:0]                      key_idx,
    input  logic [COUNT_BITS-1:0]              thr,
    output logic                               wr_en,
    output logic [IW-1:0]                      wr_addr,
    output logic [COUNT_BITS-1:0]              wr_data,
    output logic                               res_valid,
    output logic [ckms_pkg::CODE_W-1:0]        res_codes [ckms_pkg::MAX_SLOTS],
    output logic [ckms_pkg::FOUND_W-1:0]       res_found,
    output logic                               res_pressed
);

    localparam int CW = (COUNT_BITS < ckms_pkg::CHG_W) ? COUNT_BITS : ckms_pkg::CHG_W;

    logic [COUNT_BITS-1:0]            cnt;
    logic [COUNT_BITS:0]              sum;
    logic [COUNT_BITS-1:0]            run_max_reg, run_max_next, max_upd;
    logic [ckms_pkg::CODE_W-1:0]      slots_reg [REPORT_SLOTS];
    logic [ckms_pkg::CODE_W-1:0]      slots_upd [REPORT_SLOTS];
    logic [ckms_pkg::FOUND_W-1:0]     count_reg, count_upd;
    logic                             ind_reg, ind_upd;
    logic                             pressed;
    logic [ckms_pkg::CODE_W-1:0]      code;

    assign cnt  = COUNT_BITS'(charge[CW-1:0]);
    assign sum  = {1'b0, cnt} + (COUNT_BITS+1)'(margin);
    assign code = ckms_pkg::key_code(row, col);

    // calibration: raise the threshold, saturating
    assign wr_en   = fire && calibrate && key_ok && (cnt > thr);
    assign wr_addr = key_idx;
    assign wr_data = sum[COUNT_BITS] ? '1 : sum[COUNT_BITS-1:0];

    assign max_upd = (cnt > run_max_reg) ? cnt : run_max_reg;
    assign pressed = key_ok && (max_upd > thr);

    always_comb begin
        slots_upd = slots_reg;
        count_upd = count_reg;
        ind_upd   = ind_reg;
        if (!calibrate && last_sample) begin
            ind_upd = pressed;
            if (pressed && (int'(count_reg) < REPORT_SLOTS)) begin
                for (int k = 0; k < REPORT_SLOTS; k++) begin
                    if (count_reg == ckms_pkg::FOUND_W'(k)) begin
                        slots_upd[k] = code;
                    end
                end
                count_upd = count_reg + 1'b1;
            end
        end
    end

    always_comb begin
        if (calibrate || last_sample) begin
            run_max_next = '0;
        end else begin
            run_max_next = max_upd;
        end
    end

    assign res_valid   = !calibrate && last_key;
    assign res_found   = count_upd;
    assign res_pressed = ind_upd;

    for (genvar g = 0; g < ckms_pkg::MAX_SLOTS; g++) begin : g_code
        if (g < REPORT_SLOTS) begin : g_used
            assign res_codes[g] = slots_upd[g];
        end else begin : g_unused
            assign res_codes[g] = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_max_reg <= '0;
            count_reg   <= '0;
            ind_reg     <= 1'b0;
            for (int k = 0; k < REPORT_SLOTS; k++) begin
                slots_reg[k] <= '0;
            end
        end else if (fire) begin
            run_max_reg <= run_max_next;
            ind_reg     <= ind_upd;
            if (res_valid) begin
                // report goes out; start the next one empty
                count_reg <= '0;
                for (int k = 0; k < REPORT_SLOTS; k++) begin
                    slots_reg[k] <= '0;
                end
            end else begin
                count_reg <= count_upd;
                slots_reg <= slots_upd;
            end
        end
    end

endmodule

[sv/capacitive_key_matrix_scanner.sv]
// Top level of the capacitive key matrix scanner: stream ports, input
// register, output register and configuration. Depends on ckms_pkg,
// ckms_thr_store and ckms_scan_core.
//
//  channel | dir | tdata (low bit up)                       | side bands
//  --------+-----+------------------------------------------+----------------------------
//  s_      | in  | key_row, key_col, charge_count            | tuser last_sample_of_key,
//          |     |                                          | tlast last_key_of_scan
//  m_      | out | key_code_1..key_code_6, keys_found        | tuser last_key_pressed
//  cfg_    | in  | index 0 calibrate_mode, 1 threshold_margin| write only
//
// One sample per cycle, except while a full output register holds back the
// sample that closes a scan. A transaction is held in the input register
// while its threshold is read from the threshold memory, then decided and
// written into the report or threshold store; m_tvalid rises once the closing
// sample has been decided and its report loaded into the output register.
// aresetn is synchronous and clears all thresholds (valid bits), the
// report and the indicator at once; no clearing pass is needed.
// A full output register only holds the input side when the sample in the
// input register closes a scan; other samples keep flowing.
module capacitive_key_matrix_scanner #(
    parameter int ROWS         = 5,
    parameter int COLS         = 9,
    parameter int COUNT_BITS   = 16,
    parameter int REPORT_SLOTS = 6
) (
    input  logic        aclk,
    input  logic        aresetn,
    // input samples
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // key_row[2:0], key_col[6:3], charge_count[22:7]
    input  logic        s_tuser,   // last_sample_of_key
    input  logic        s_tlast,   // last_key_of_scan
    // reports
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // key_code_1[7:0] .. key_code_6[47:40], keys_found[50:48]
    output logic        m_tuser,   // last_key_pressed
    // configuration writes
    input  logic        cfg_we,
    input  logic [0:0]  cfg_addr,
    input  logic [7:0]  cfg_wdata
);

    localparam int KEYS = ROWS * COLS;
    localparam int IW   = (KEYS > 1) ? $clog2(KEYS) : 1;
    localparam int RW   = ckms_pkg::ROW_W;
    localparam int CLW  = ckms_pkg::COL_W;
    localparam int CGW  = ckms_pkg::CHG_W;
    localparam int CDW  = ckms_pkg::CODE_W;
    localparam int FW   = ckms_pkg::FOUND_W;

    // configuration
    logic       calibrate_reg;
    logic [7:0] margin_reg;

    // input register
    logic           p_valid_reg, p_valid_next;
    logic [RW-1:0]  p_row_reg;
    logic [CLW-1:0] p_col_reg;
    logic [CGW-1:0] p_charge_reg;
    logic           p_last_sample_reg, p_last_key_reg;
    logic           p_ok_reg;
    logic [IW-1:0]  p_idx_reg;

    // decoded incoming key position
    logic [RW-1:0]  in_row;
    logic [CLW-1:0] in_col;
    logic           in_ok;
    logic [IW-1:0]  in_idx;

    logic accept, fire, p_done;

    logic                  wr_en;
    logic [IW-1:0]         wr_addr;
    logic [COUNT_BITS-1:0] wr_data;
    logic [COUNT_BITS-1:0] thr;

    logic           res_valid;
    logic [CDW-1:0] res_codes [ckms_pkg::MAX_SLOTS];
    logic [FW-1:0]  res_found;
    logic           res_pressed;

    // output register
    logic           m_valid_reg, m_valid_next;
    logic [55:0]    m_data_reg;
    logic           m_user_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            calibrate_reg <= 1'b0;
            margin_reg    <= ckms_pkg::MARGIN_RESET;
        end else if (cfg_we) begin
            case (cfg_addr)
                ckms_pkg::CFG_CALIBRATE_MODE:   calibrate_reg <= cfg_wdata[0];
                ckms_pkg::CFG_THRESHOLD_MARGIN: margin_reg    <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // key position: out-of-range keys map to entry zero and never decide pressed
    assign in_row = s_tdata[2:0];
    assign in_col = s_tdata[6:3];
    assign in_ok  = (int'(in_row) < ROWS) && (int'(in_col) < COLS);
    assign in_idx = in_ok ? IW'(int'(in_row) * COLS + int'(in_col)) : '0;

    // hold the input register only while it carries a report the output cannot take
    assign p_done   = !res_valid || !m_valid_reg || m_tready;
    assign fire     = p_valid_reg && p_done;
    assign s_tready = !p_valid_reg || p_done;
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        p_valid_next = p_valid_reg;
        if (accept) begin
            p_valid_next = 1'b1;
        end else if (fire) begin
            p_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p_valid_reg <= 1'b0;
        end else begin
            p_valid_reg <= p_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            p_row_reg         <= in_row;
            p_col_reg         <= in_col;
            p_charge_reg      <= s_tdata[22:7];
            p_last_sample_reg <= s_tuser;
            p_last_key_reg    <= s_tlast;
            p_ok_reg          <= in_ok;
            p_idx_reg         <= in_idx;
        end
    end

    ckms_thr_store #(
        .KEYS       (KEYS),
        .IW         (IW),
        .COUNT_BITS (COUNT_BITS)
    ) u_thr_store (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_en   (accept),
        .rd_addr (in_idx),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_thr  (thr)
    );

    ckms_scan_core #(
        .IW           (IW),
        .COUNT_BITS   (COUNT_BITS),
        .REPORT_SLOTS (REPORT_SLOTS)
    ) u_scan_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .fire        (fire),
        .calibrate   (calibrate_reg),
        .margin      (margin_reg),
        .row         (p_row_reg),
        .col         (p_col_reg),
        .charge      (p_charge_reg),
        .last_sample (p_last_sample_reg),
        .last_key    (p_last_key_reg),
        .key_ok      (p_ok_reg),
        .key_idx     (p_idx_reg),
        .thr         (thr),
        .wr_en       (wr_en),
        .wr_addr     (wr_addr),
        .wr_data     (wr_data),
        .res_valid   (res_valid),
        .res_codes   (res_codes),
        .res_found   (res_found),
        .res_pressed (res_pressed)
    );

    // load a finished report, drop the valid once the transaction is taken
    always_comb begin
        m_valid_next = m_valid_reg;
        if (fire && res_valid) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire && res_valid) begin
            m_data_reg <= {5'd0, res_found, res_codes[5], res_codes[4], res_codes[3],
                           res_codes[2], res_codes[1], res_codes[0]};
            m_user_reg <= res_pressed;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

endmodule
